### hw/rtl/modular_exponentiation_core_defines.svh
// Assertion macros used by the checker of the modular exponentiation core
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MXP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MXP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/mxp_pkg.sv
`timescale 1ns / 1ps
package mxp_pkg;

    localparam int          OPERAND_BITS_DEF  = 32;
    localparam int          EXPONENT_BITS_DEF = 32;
    localparam logic [63:0] MODULUS_RESET     = 64'd1000000009;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_SQUARE,
        S_MULT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
    } t_mul_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

### hw/rtl/mxp_mul_unit.sv
`timescale 1ns / 1ps
module mxp_mul_unit import mxp_pkg::*; #(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mul_ctl                i_ctl,
    input  logic [OPERAND_BITS-1:0] i_a,
    input  logic [OPERAND_BITS-1:0] i_mplr,
    input  logic [OPERAND_BITS-1:0] i_m,
    output t_mul_stat               o_stat,
    output logic [OPERAND_BITS-1:0] o_result
);

    localparam int CNT_W = $clog2(OPERAND_BITS);
    localparam int SUM_W = OPERAND_BITS + 2;

    logic [OPERAND_BITS-1:0] r_acc,  n_acc;
    logic [OPERAND_BITS-1:0] r_a;
    logic [OPERAND_BITS-1:0] r_mplr;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy;
    logic                    r_done;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] m_one;
    logic [SUM_W-1:0] m_two;
    logic [SUM_W-1:0] red;

    always_comb begin
        m_one = {2'b00, i_m};
        m_two = {1'b0, i_m, 1'b0};
        sum   = {1'b0, r_acc, 1'b0} + (r_mplr[OPERAND_BITS-1] ? {2'b00, r_a} : '0);
        if (sum >= m_two) begin
            red = sum - m_two;
        end else if (sum >= m_one) begin
            red = sum - m_one;
        end else begin
            red = sum;
        end
        n_acc = red[OPERAND_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start && !r_busy) begin
            r_acc  <= '0;
            r_a    <= i_a;
            r_mplr <= i_mplr;
            r_cnt  <= CNT_W'(OPERAND_BITS - 1);
        end else if (r_busy) begin
            r_acc  <= n_acc;
            r_mplr <= {r_mplr[OPERAND_BITS-2:0], 1'b0};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_acc;

endmodule

### hw/rtl/modular_exponentiation_core.sv
`timescale 1ns / 1ps
// Each request runs a reduce step, then a square step per exponent bit and a multiply step per
// set exponent bit, all on the bit-serial modular multiplier shared by all steps.
// A zero modulus skips the multiplier and gives a zero result through S_DONE.
// A request is taken only in S_IDLE; a stalled result holds the next result in S_DONE.
// Reset: synchronous active-low i_rst_n clears control and loads the modulus with 1000000009.
module modular_exponentiation_core import mxp_pkg::*; #(
    parameter int OPERAND_BITS  = OPERAND_BITS_DEF,
    parameter int EXPONENT_BITS = EXPONENT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [OPERAND_BITS-1:0]  i_base_value,
    input  logic [EXPONENT_BITS-1:0] i_exponent,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [OPERAND_BITS-1:0]  o_power_result,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [OPERAND_BITS-1:0]  i_cfg_modulus
);

    localparam int IDX_W = (EXPONENT_BITS > 1) ? $clog2(EXPONENT_BITS) : 1;

    t_state                   r_state, n_state;
    logic                     r_issue, n_issue;
    logic [IDX_W-1:0]         r_idx,   n_idx;
    logic [OPERAND_BITS-1:0]  r_run,   n_run;
    logic [OPERAND_BITS-1:0]  r_bred,  n_bred;
    logic [OPERAND_BITS-1:0]  r_base;
    logic [EXPONENT_BITS-1:0] r_exp;
    logic [OPERAND_BITS-1:0]  r_modulus;
    logic [OPERAND_BITS-1:0]  r_result;
    logic                     r_out_valid;

    logic                    in_take;
    logic                    out_load;
    logic                    slot_free;
    logic [OPERAND_BITS-1:0] one_m;
    logic [OPERAND_BITS-1:0] op_a;
    logic [OPERAND_BITS-1:0] op_mplr;
    logic [OPERAND_BITS-1:0] mul_res;
    t_mul_ctl                mul_ctl;
    t_mul_stat               mul_stat;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign one_m       = (r_modulus == OPERAND_BITS'(1)) ? '0 : OPERAND_BITS'(1);

    mxp_mul_unit #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mul_ctl),
        .i_a      (op_a),
        .i_mplr   (op_mplr),
        .i_m      (r_modulus),
        .o_stat   (mul_stat),
        .o_result (mul_res)
    );

    always_comb begin
        n_state       = r_state;
        n_issue       = 1'b0;
        n_idx         = r_idx;
        n_run         = r_run;
        n_bred        = r_bred;
        out_load      = 1'b0;
        mul_ctl.start = 1'b0;
        op_a          = r_run;
        op_mplr       = r_run;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (r_modulus == '0) begin
                        n_run   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_issue = 1'b1;
                        n_state = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                op_a          = one_m;
                op_mplr       = r_base;
                mul_ctl.start = r_issue && !mul_stat.busy;
                if (mul_stat.done) begin
                    n_bred  = mul_res;
                    n_run   = one_m;
                    n_idx   = IDX_W'(EXPONENT_BITS - 1);
                    n_issue = 1'b1;
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: begin
                mul_ctl.start = r_issue && !mul_stat.busy;
                if (mul_stat.done) begin
                    n_run = mul_res;
                    if (r_exp[r_idx]) begin
                        n_issue = 1'b1;
                        n_state = S_MULT;
                    end else if (r_idx == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_issue = 1'b1;
                    end
                end
            end
            S_MULT: begin
                op_mplr       = r_bred;
                mul_ctl.start = r_issue && !mul_stat.busy;
                if (mul_stat.done) begin
                    n_run = mul_res;
                    if (r_idx == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_issue = 1'b1;
                        n_state = S_SQUARE;
                    end
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (r_issue && mul_stat.busy) begin
            n_issue = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_out_valid <= 1'b0;
            r_modulus   <= MODULUS_RESET[OPERAND_BITS-1:0];
        end else begin
            r_state <= n_state;
            r_issue <= n_issue && !mul_ctl.start;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_modulus <= i_cfg_modulus;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_run  <= n_run;
        r_bred <= n_bred;
        if (in_take) begin
            r_base <= i_base_value;
            r_exp  <= i_exponent;
        end
        if (out_load) begin
            r_result <= r_run;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_result;

endmodule

### hw/rtl/mxp_checker.sv
`timescale 1ns / 1ps
`include "modular_exponentiation_core_defines.svh"
module mxp_checker import mxp_pkg::*; #(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [OPERAND_BITS-1:0] o_power_result,
    input logic                    o_cfg_ready
);

    logic in_take;
    logic out_held;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_held = o_out_valid && i_out_stall;

    `MXP_ASSERT_NEXT(a_out_hold, out_held, o_out_valid && $stable(o_power_result), "result moved")
    `MXP_ASSERT_NEXT(a_busy_after_take, in_take, o_in_stall, "request taken but core not busy")
    `MXP_ASSERT_NOW(a_cfg_idle, 1'b1, o_cfg_ready == !o_in_stall, "cfg ready not idle")
    `MXP_ASSERT_NOW(a_result_from_busy, $rose(o_out_valid), $past(o_in_stall), "result idle")

endmodule

bind modular_exponentiation_core mxp_checker #(
    .OPERAND_BITS (OPERAND_BITS)
) u_mxp_checker (.*);
